// ----- sv/aes_pkg.sv -----
// Package for the AES block cipher core: item types, codes, S-box tables, round functions.
package aes_pkg;

  // Default round-key store depth in 32-bit words
  localparam int unsigned RK_WORDS_DEFAULT = 60;

  // Configuration register indexes
  localparam logic [2:0] CFG_KEY_0_7   = 3'd0;
  localparam logic [2:0] CFG_KEY_8_15  = 3'd1;
  localparam logic [2:0] CFG_KEY_16_23 = 3'd2;
  localparam logic [2:0] CFG_KEY_24_31 = 3'd3;
  localparam logic [2:0] CFG_KEY_SIZE  = 3'd4;

  // Key size codes
  localparam logic [1:0] KSIZE_128 = 2'd0;
  localparam logic [1:0] KSIZE_192 = 2'd1;

  localparam logic [7:0] RCON_INIT = 8'h01;

  typedef struct packed {
    logic        req_type;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } aes_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_PREP,
    ST_ROUND,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    NK4,
    NK6,
    NK8
  } nk_e;

  typedef enum logic [1:0] {
    RND_FIRST,
    RND_MID,
    RND_LAST
  } rnd_kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic      load;
    logic      exp_en;
    logic      exp_key;
    logic [2:0] key_idx;
    logic      pos_rot;
    logic      pos_sub;
    nk_e       nk;
    logic      row_we;
    logic [1:0] word_pos;
    logic [3:0] row_addr;
    logic [3:0] rd_addr;
    logic      rnd_en;
    rnd_kind_e rnd_kind;
    logic      dec;
  } aes_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    nk_e nk;
  } aes_status_t;

  localparam logic [7:0] SBOX_FWD [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] SBOX_INV [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // GF(2^8) doubling
  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // S-box over a 32-bit word
  function automatic logic [31:0] sub_word(input logic [31:0] x);
    sub_word = {SBOX_FWD[x[31:24]], SBOX_FWD[x[23:16]], SBOX_FWD[x[15:8]], SBOX_FWD[x[7:0]]};
  endfunction

  // State byte i (row + 4*col) sits at bits 127-8i downward
  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = inv ? SBOX_INV[s[127-8*i -: 8]] : SBOX_FWD[s[127-8*i -: 8]];
    end
    sub_bytes = r;
  endfunction

  // Row r rotates left by r, or right by r when inverse
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    int src;
    r = s;
    for (int row = 1; row < 4; row++) begin
      for (int c = 0; c < 4; c++) begin
        src = inv ? ((c + 4 - row) % 4) : ((c + row) % 4);
        r[127-8*(row+4*c) -: 8] = s[127-8*(row+4*src) -: 8];
      end
    end
    shift_rows = r;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    logic [7:0] a [4];
    logic [7:0] x0, x1, x2, x3;
    logic [7:0] y2, y4, y8;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k] = s[127-8*(4*c+k) -: 8];
      end
      for (int row = 0; row < 4; row++) begin
        x0 = a[row];
        x1 = a[(row+1)%4];
        x2 = a[(row+2)%4];
        x3 = a[(row+3)%4];
        if (inv) begin
          // 0e*x0 ^ 0b*x1 ^ 0d*x2 ^ 09*x3
          y2 = xtime(x0); y4 = xtime(y2); y8 = xtime(y4);
          r[127-8*(4*c+row) -: 8] = y8 ^ y4 ^ y2;
          y2 = xtime(x1); y4 = xtime(y2); y8 = xtime(y4);
          r[127-8*(4*c+row) -: 8] = r[127-8*(4*c+row) -: 8] ^ y8 ^ y2 ^ x1;
          y2 = xtime(x2); y4 = xtime(y2); y8 = xtime(y4);
          r[127-8*(4*c+row) -: 8] = r[127-8*(4*c+row) -: 8] ^ y8 ^ y4 ^ x2;
          y2 = xtime(x3); y4 = xtime(y2); y8 = xtime(y4);
          r[127-8*(4*c+row) -: 8] = r[127-8*(4*c+row) -: 8] ^ y8 ^ x3;
        end else begin
          r[127-8*(4*c+row) -: 8] = xtime(x0) ^ xtime(x1) ^ x1 ^ x2 ^ x3;
        end
      end
    end
    mix_columns = r;
  endfunction

endpackage

// ----- sv/aes_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module aes_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 15
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/aes_ctrl.sv -----
// Controller: sequences key expansion, round steps and the result strobe.
module aes_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 req_type_i,
  input  aes_pkg::aes_status_t status_i,
  output aes_pkg::aes_cmd_t    cmd_o,
  output logic                 busy,
  output logic                 done_o
);

  aes_pkg::state_e state_q, state_d;
  aes_pkg::nk_e    nk_q, nk_d;
  logic            dec_q, dec_d;
  logic [5:0]      widx_q, widx_d;
  logic [2:0]      pos_q, pos_d;
  logic [3:0]      step_q, step_d;

  logic [3:0] nk_num;
  logic [3:0] nr;
  logic [5:0] last_word;
  logic [3:0] step_nx;

  // Key length in words, round count and last schedule word
  always_comb begin
    unique case (nk_q)
      aes_pkg::NK4: nk_num = 4'd4;
      aes_pkg::NK6: nk_num = 4'd6;
      aes_pkg::NK8: nk_num = 4'd8;
      default:      nk_num = 4'd4;
    endcase
    nr        = nk_num + 4'd6;
    last_word = 6'({2'b00, nk_num} + 6'd7) * 6'd4 - 6'd1;
    step_nx   = step_q + 4'd1;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      aes_pkg::ST_IDLE:   if (start) state_d = aes_pkg::ST_EXPAND;
      aes_pkg::ST_EXPAND: if (widx_q == last_word) state_d = aes_pkg::ST_PREP;
      aes_pkg::ST_PREP:   state_d = aes_pkg::ST_ROUND;
      aes_pkg::ST_ROUND:  if (step_q == nr) state_d = aes_pkg::ST_DONE;
      aes_pkg::ST_DONE:   state_d = aes_pkg::ST_IDLE;
      default:            state_d = aes_pkg::ST_IDLE;
    endcase
  end

  // Counters and latched item info
  always_comb begin
    nk_d   = nk_q;
    dec_d  = dec_q;
    widx_d = widx_q;
    pos_d  = pos_q;
    step_d = step_q;
    unique case (state_q)
      aes_pkg::ST_IDLE: begin
        if (start) begin
          nk_d   = status_i.nk;
          dec_d  = req_type_i;
          widx_d = '0;
          pos_d  = '0;
        end
      end
      aes_pkg::ST_EXPAND: begin
        widx_d = widx_q + 6'd1;
        pos_d  = ({1'b0, pos_q} == nk_num - 4'd1) ? 3'd0 : pos_q + 3'd1;
      end
      aes_pkg::ST_PREP:  step_d = '0;
      aes_pkg::ST_ROUND: step_d = step_nx;
      default: ;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o          = '0;
    cmd_o.nk       = nk_q;
    cmd_o.dec      = dec_q;
    cmd_o.key_idx  = widx_q[2:0];
    cmd_o.word_pos = widx_q[1:0];
    cmd_o.row_addr = widx_q[5:2];
    cmd_o.rnd_kind = aes_pkg::RND_MID;
    busy           = 1'b1;
    done_o         = 1'b0;
    unique case (state_q)
      aes_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      aes_pkg::ST_EXPAND: begin
        cmd_o.exp_en  = 1'b1;
        cmd_o.exp_key = ({2'b00, widx_q} < {2'b00, nk_num, 2'b00} >> 2);
        cmd_o.pos_rot = (pos_q == 3'd0);
        cmd_o.pos_sub = (nk_q == aes_pkg::NK8) && (pos_q == 3'd4);
        cmd_o.row_we  = (widx_q[1:0] == 2'd3);
      end
      aes_pkg::ST_PREP: begin
        cmd_o.rd_addr = dec_q ? nr : 4'd0;
      end
      aes_pkg::ST_ROUND: begin
        cmd_o.rnd_en   = 1'b1;
        cmd_o.rd_addr  = dec_q ? nr - step_nx : step_nx;
        if (step_q == 4'd0) begin
          cmd_o.rnd_kind = aes_pkg::RND_FIRST;
        end else if (step_q == nr) begin
          cmd_o.rnd_kind = aes_pkg::RND_LAST;
        end
      end
      aes_pkg::ST_DONE: begin
        done_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aes_pkg::ST_IDLE;
      nk_q    <= aes_pkg::NK4;
      dec_q   <= 1'b0;
      widx_q  <= '0;
      pos_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      nk_q    <= nk_d;
      dec_q   <= dec_d;
      widx_q  <= widx_d;
      pos_q   <= pos_d;
      step_q  <= step_d;
    end
  end

endmodule

// ----- sv/aes_datapath.sv -----
// Datapath: key registers, key schedule window, round-key RAM and the round unit.
module aes_datapath #(
  parameter int unsigned ROUND_KEY_WORDS = aes_pkg::RK_WORDS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [63:0]          cfg_data_i,
  input  aes_pkg::aes_in_t     item_i,
  input  aes_pkg::aes_cmd_t    cmd_i,
  output aes_pkg::aes_status_t status_o,
  output aes_pkg::aes_out_t    result_o
);

  localparam int unsigned RK_DEPTH = (ROUND_KEY_WORDS > 44) ? ROUND_KEY_WORDS : 44;
  localparam int unsigned ROWS     = (RK_DEPTH + 3) / 4;
  localparam int unsigned AW       = $clog2(ROWS);

  logic [63:0]  key_q [4];
  logic [1:0]   ksize_q;
  logic [31:0]  win_q [8];
  logic [31:0]  rowbuf_q [3];
  logic [7:0]   rcon_q;
  logic [127:0] state_q;

  logic [255:0] key_all;
  logic [31:0]  key_word;
  logic [31:0]  tap;
  logic [31:0]  tmp;
  logic [31:0]  new_word;
  logic [127:0] rk;
  logic [127:0] sbsh;
  logic [127:0] round_out;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      ksize_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        aes_pkg::CFG_KEY_0_7:   key_q[0] <= cfg_data_i;
        aes_pkg::CFG_KEY_8_15:  key_q[1] <= cfg_data_i;
        aes_pkg::CFG_KEY_16_23: key_q[2] <= cfg_data_i;
        aes_pkg::CFG_KEY_24_31: key_q[3] <= cfg_data_i;
        aes_pkg::CFG_KEY_SIZE:  ksize_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Effective key length; falls back when the store is too shallow
  always_comb begin
    if (ksize_q == aes_pkg::KSIZE_128) begin
      status_o.nk = aes_pkg::NK4;
    end else if (ksize_q == aes_pkg::KSIZE_192 || RK_DEPTH < 60) begin
      status_o.nk = (RK_DEPTH >= 52) ? aes_pkg::NK6 : aes_pkg::NK4;
    end else begin
      status_o.nk = aes_pkg::NK8;
    end
  end

  // Next schedule word
  always_comb begin
    key_all  = {key_q[0], key_q[1], key_q[2], key_q[3]};
    key_word = key_all[255 - 32*cmd_i.key_idx -: 32];
    case (cmd_i.nk)
      aes_pkg::NK6: tap = win_q[5];
      aes_pkg::NK8: tap = win_q[7];
      default:      tap = win_q[3];
    endcase
    if (cmd_i.pos_rot) begin
      tmp = aes_pkg::sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rcon_q, 24'h0};
    end else if (cmd_i.pos_sub) begin
      tmp = aes_pkg::sub_word(win_q[0]);
    end else begin
      tmp = win_q[0];
    end
    new_word = cmd_i.exp_key ? key_word : (tap ^ tmp);
  end

  // Schedule window, row assembly and round constant
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rcon_q <= aes_pkg::RCON_INIT;
    end else if (cmd_i.exp_en && !cmd_i.exp_key && cmd_i.pos_rot) begin
      rcon_q <= aes_pkg::xtime(rcon_q);
    end
    if (cmd_i.exp_en) begin
      win_q[0] <= new_word;
      for (int i = 1; i < 8; i++) win_q[i] <= win_q[i-1];
      if (cmd_i.word_pos != 2'd3) rowbuf_q[cmd_i.word_pos] <= new_word;
    end
  end

  // Round-key store, one round (four words) per row
  aes_ram #(
    .WIDTH (128),
    .DEPTH (ROWS)
  ) u_rk_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.row_we),
    .waddr_i (AW'(cmd_i.row_addr)),
    .wdata_i ({rowbuf_q[0], rowbuf_q[1], rowbuf_q[2], new_word}),
    .raddr_i (AW'(cmd_i.rd_addr)),
    .rdata_o (rk)
  );

  // Shared round unit
  always_comb begin
    if (cmd_i.dec) begin
      sbsh = aes_pkg::sub_bytes(aes_pkg::shift_rows(state_q, 1'b1), 1'b1);
    end else begin
      sbsh = aes_pkg::shift_rows(aes_pkg::sub_bytes(state_q, 1'b0), 1'b0);
    end
    case (cmd_i.rnd_kind)
      aes_pkg::RND_FIRST: round_out = state_q ^ rk;
      aes_pkg::RND_MID:   round_out = cmd_i.dec ? aes_pkg::mix_columns(sbsh ^ rk, 1'b1)
                                                : aes_pkg::mix_columns(sbsh, 1'b0) ^ rk;
      default:            round_out = sbsh ^ rk;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      state_q <= {item_i.block_hi, item_i.block_lo};
    end else if (cmd_i.rnd_en) begin
      state_q <= round_out;
    end
  end

  assign result_o.result_hi = state_q[127:64];
  assign result_o.result_lo = state_q[63:0];

endmodule

// ----- sv/aes_block_cipher_core.sv -----
// Top level of the AES-128/192/256 single-block cipher core.
//
//  channel  | ports                            | handshake
//  ---------+----------------------------------+---------------------------
//  item in  | start, busy, item_i              | taken when start && !busy
//  result   | done_o, result_o                 | valid for one cycle
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i  | written when cfg_we_i
//
// An item runs key expansion (one schedule word per cycle through the key
// window), a fetch of the first round-key row, and Nr+1 rounds on the shared
// round unit, one RAM row per round; done_o follows.
// Reset is asynchronous, active low, and returns the controller to idle.
// The result receiver cannot stall; busy stays high until done_o has pulsed.
module aes_block_cipher_core #(
  parameter int unsigned ROUND_KEY_WORDS = aes_pkg::RK_WORDS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  aes_pkg::aes_in_t  item_i,
  output logic              done_o,
  output aes_pkg::aes_out_t result_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [63:0]       cfg_data_i
);

  aes_pkg::aes_cmd_t    cmd;
  aes_pkg::aes_status_t status;

  aes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (item_i.req_type),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy       (busy),
    .done_o     (done_o)
  );

  aes_datapath #(
    .ROUND_KEY_WORDS (ROUND_KEY_WORDS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .result_o   (result_o)
  );

endmodule

// ----- dv/tb_aes_block_cipher_core.sv -----
// Self-checking testbench for the AES block cipher core: key-schedule and cipher predictor.
module tb_aes_block_cipher_core;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 90;
  // Register indexes that decode to nothing
  localparam logic [2:0] CFG_SPARE_5 = 3'd5;
  localparam logic [2:0] CFG_SPARE_7 = 3'd7;
  localparam logic [1:0] KSIZE_256   = 2'd2;
  localparam logic [1:0] KSIZE_ODD   = 2'd3;
  localparam logic       REQ_ENC     = 1'b0;
  localparam logic       REQ_DEC     = 1'b1;

  typedef logic [7:0]  cstate_t [16];
  typedef logic [31:0] sched_t [60];

  // Expected ciphertext / plaintext store and mismatch count
  class aes_scoreboard;
    aes_pkg::aes_out_t pending_q[$];
    int unsigned       errors;

    function new();
      errors = 0;
    endfunction

    task report(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    task note_item(input aes_pkg::aes_out_t exp_blk);
      pending_q.push_back(exp_blk);
    endtask

    task check_result(input aes_pkg::aes_out_t got);
      aes_pkg::aes_out_t exp_blk;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
      end else begin
        exp_blk = pending_q.pop_front();
        if (got.result_hi !== exp_blk.result_hi)
          report($sformatf("result_hi got %h exp %h", got.result_hi, exp_blk.result_hi));
        if (got.result_lo !== exp_blk.result_lo)
          report($sformatf("result_lo got %h exp %h", got.result_lo, exp_blk.result_lo));
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  aes_pkg::aes_in_t  item_i = '0;
  logic              done_o;
  aes_pkg::aes_out_t result_o;
  logic              cfg_we_i = 1'b0;
  logic [2:0]        cfg_idx_i = '0;
  logic [63:0]       cfg_data_i = '0;

  aes_scoreboard sb = new();

  // Configuration shadow
  logic [63:0] key_words_q [4] = '{default: '0};
  logic [1:0]  key_size_q = aes_pkg::KSIZE_128;

  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;

  aes_block_cipher_core u_top (
    .clk_i, .rst_ni, .start, .busy, .item_i, .done_o, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("aes_block_cipher_core verification failed");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(result_o);
  end

  // ---------------- predictor ----------------
  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_double(a);
    end
    return acc;
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] x);
    return {aes_pkg::SBOX_FWD[x[31:24]], aes_pkg::SBOX_FWD[x[23:16]],
            aes_pkg::SBOX_FWD[x[15:8]], aes_pkg::SBOX_FWD[x[7:0]]};
  endfunction

  function automatic cstate_t add_round_key(input cstate_t s, input sched_t w, input int rnd);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        s[r+4*c] ^= w[4*rnd+c][31-8*r -: 8];
    return s;
  endfunction

  function automatic cstate_t subst_bytes(input cstate_t s, input logic inv);
    for (int i = 0; i < 16; i++)
      s[i] = inv ? aes_pkg::SBOX_INV[s[i]] : aes_pkg::SBOX_FWD[s[i]];
    return s;
  endfunction

  function automatic cstate_t rotate_rows(input cstate_t s, input logic inv);
    cstate_t t;
    int src;
    t = s;
    for (int r = 1; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        src = inv ? (c + 4 - r) % 4 : (c + r) % 4;
        s[r+4*c] = t[r+4*src];
      end
    return s;
  endfunction

  function automatic cstate_t mix_cols(input cstate_t s, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x0, x1, x2, x3;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) a[k] = s[4*c+k];
      for (int r = 0; r < 4; r++) begin
        x0 = a[r]; x1 = a[(r+1)%4]; x2 = a[(r+2)%4]; x3 = a[(r+3)%4];
        if (inv)
          s[4*c+r] = gf_mult(x0, 8'h0e) ^ gf_mult(x1, 8'h0b) ^ gf_mult(x2, 8'h0d)
                   ^ gf_mult(x3, 8'h09);
        else
          s[4*c+r] = gf_double(x0) ^ gf_double(x1) ^ x1 ^ x2 ^ x3;
      end
    end
    return s;
  endfunction

  // Full block: key expansion from the shadow registers, then the cipher
  function automatic aes_pkg::aes_out_t cipher_block(input aes_pkg::aes_in_t it);
    sched_t            w;
    cstate_t           s;
    int                nk, nr;
    logic [7:0]        rc;
    logic [31:0]       tmp;
    aes_pkg::aes_out_t res;
    w = '{default: '0};
    // size code three behaves as 256 bits
    nk = (key_size_q == aes_pkg::KSIZE_128) ? 4 : (key_size_q == aes_pkg::KSIZE_192) ? 6 : 8;
    nr = nk + 6;
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      w[i] = (i % 2) ? key_words_q[i/2][31:0] : key_words_q[i/2][63:32];
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      tmp = w[i-1];
      if (i % nk == 0) begin
        tmp = sbox_word({tmp[23:0], tmp[31:24]}) ^ {rc, 24'h0};
        rc  = gf_double(rc);
      end else if (nk > 6 && i % nk == 4) begin
        tmp = sbox_word(tmp);
      end
      w[i] = w[i-nk] ^ tmp;
    end
    for (int i = 0; i < 8; i++) begin
      s[i]   = it.block_hi[63-8*i -: 8];
      s[8+i] = it.block_lo[63-8*i -: 8];
    end
    if (it.req_type == REQ_ENC) begin
      s = add_round_key(s, w, 0);
      for (int rnd = 1; rnd < nr; rnd++) begin
        s = mix_cols(rotate_rows(subst_bytes(s, 1'b0), 1'b0), 1'b0);
        s = add_round_key(s, w, rnd);
      end
      s = add_round_key(rotate_rows(subst_bytes(s, 1'b0), 1'b0), w, nr);
    end else begin
      s = add_round_key(s, w, nr);
      for (int rnd = nr - 1; rnd >= 1; rnd--) begin
        s = add_round_key(subst_bytes(rotate_rows(s, 1'b1), 1'b1), w, rnd);
        s = mix_cols(s, 1'b1);
      end
      s = add_round_key(subst_bytes(rotate_rows(s, 1'b1), 1'b1), w, 0);
    end
    for (int i = 0; i < 8; i++) begin
      res.result_hi[63-8*i -: 8] = s[i];
      res.result_lo[63-8*i -: 8] = s[8+i];
    end
    return res;
  endfunction

  // ---------------- drivers ----------------
  // Register write; enable stays high until cfg_close
  task cfg_write(input logic [2:0] idx, input logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      aes_pkg::CFG_KEY_0_7:   key_words_q[0] = data;
      aes_pkg::CFG_KEY_8_15:  key_words_q[1] = data;
      aes_pkg::CFG_KEY_16_23: key_words_q[2] = data;
      aes_pkg::CFG_KEY_24_31: key_words_q[3] = data;
      aes_pkg::CFG_KEY_SIZE:  key_size_q = data[1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task cfg_close();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task load_key(input logic [63:0] k0, k1, k2, k3, input logic [1:0] ksize);
    cfg_write(aes_pkg::CFG_KEY_0_7, k0);
    cfg_write(aes_pkg::CFG_KEY_8_15, k1);
    cfg_write(aes_pkg::CFG_KEY_16_23, k2);
    cfg_write(aes_pkg::CFG_KEY_24_31, k3);
    cfg_write(aes_pkg::CFG_KEY_SIZE, {$urandom, $urandom} & ~64'h3 | 64'(ksize));
    cfg_close();
  endtask

  // Present one item; start stays high into the next item when no gap follows
  task send_block(input aes_pkg::aes_in_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    sb.note_item(cipher_block(it));
  endtask

  // Wait for the core to go quiet before touching configuration
  task drain();
    start <= 1'b0;
    do @(posedge clk_i); while (busy || sb.pending_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic aes_pkg::aes_in_t mk_item(input logic req, input logic [63:0] hi, lo);
    aes_pkg::aes_in_t it;
    it.req_type = req;
    it.block_hi = hi;
    it.block_lo = lo;
    return it;
  endfunction

  // ---------------- test sequence ----------------
  initial begin
    int unsigned n_items;
    logic [1:0]  ksz;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset key (all zero, 128-bit), then the standard test keys
    send_block(mk_item(REQ_ENC, 64'h0, 64'h0));
    send_block(mk_item(REQ_DEC, '1, '1));
    drain();
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
             64'h18191a1b1c1d1e1f, aes_pkg::KSIZE_128);
    send_block(mk_item(REQ_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff));
    send_block(mk_item(REQ_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a));
    drain();
    cfg_write(aes_pkg::CFG_KEY_SIZE, 64'(aes_pkg::KSIZE_192));
    cfg_close();
    send_block(mk_item(REQ_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff));
    send_block(mk_item(REQ_DEC, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191));
    drain();
    cfg_write(aes_pkg::CFG_KEY_SIZE, 64'(KSIZE_256));
    cfg_close();
    send_block(mk_item(REQ_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff));
    send_block(mk_item(REQ_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089));
    drain();
    // Size code three, writes to undecoded indexes
    cfg_write(aes_pkg::CFG_KEY_SIZE, 64'(KSIZE_ODD));
    cfg_write(CFG_SPARE_5, '1);
    cfg_write(CFG_SPARE_7, 64'h5a5a5a5a5a5a5a5a);
    cfg_close();
    send_block(mk_item(REQ_ENC, '1, 64'h0));
    send_block(mk_item(REQ_DEC, 64'h0, '1));
    drain();
    // All-ones key at each size, checkerboard blocks
    for (int k = 0; k < 3; k++) begin
      load_key('1, '1, '1, '1, 2'(k));
      send_block(mk_item(REQ_ENC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555));
      send_block(mk_item(REQ_DEC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa));
      drain();
    end

    // Random phases: sender idles 16%, then 79%, then never
    n_items = 0;
    while (n_items < 850) begin
      send_idle_pct = (n_items < 280) ? 16 : (n_items < 560) ? 79 : 0;
      ksz = 2'($urandom_range(3));
      load_key(rand64(), rand64(), rand64(), rand64(), ksz);
      if ($urandom_range(3) == 0) begin
        cfg_write(3'($urandom_range(5, 7)), {$urandom, $urandom});
        cfg_close();
      end
      repeat ($urandom_range(10, 40)) begin
        send_block(mk_item(1'($urandom), rand64(), rand64()));
        n_items++;
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));
    if (sb.errors == 0) begin
      $display("aes_block_cipher_core verification clean");
    end else begin
      $display("aes_block_cipher_core verification failed");
    end
    $finish;
  end

endmodule
